// ----- design/ybd_pkg.sv -----
// Shared types and constants for the 4x4 block decoder.
package ybd_pkg;

	typedef struct packed {
		logic [63:0] block_word3;
		logic [63:0] block_word2;
		logic [63:0] block_word1;
		logic [63:0] block_word0;
	} blk_in_t;

	typedef struct packed {
		logic [31:0] chroma_v;
		logic [31:0] chroma_u;
		logic [31:0] luma_row3;
		logic [31:0] luma_row2;
		logic [31:0] luma_row1;
		logic [31:0] luma_row0;
	} blk_out_t;

	localparam logic [2:0] MODE_PAL4  = 3'd0;
	localparam logic [2:0] MODE_FLAT  = 3'd1;
	localparam logic [2:0] MODE_SUB   = 3'd2;
	localparam logic [2:0] MODE_BIT1  = 3'd3;
	localparam logic [2:0] MODE_PAL8  = 3'd4;
	localparam logic [2:0] MODE_QUAD  = 3'd5;
	localparam logic [2:0] MODE_RAW   = 3'd6;
	localparam logic [2:0] MODE_CHECK = 3'd7;

	localparam logic [7:0] CODE_SUB  = 8'd1;
	localparam logic [7:0] CODE_BIT1 = 8'd2;
	localparam logic [7:0] CODE_PAL8 = 8'd6;
	localparam logic [7:0] CODE_RAW  = 8'd7;
	localparam logic [7:0] CODE_QUAD = 8'd17;

	localparam logic [7:0] PIX_MAX = 8'd255;

	// Endpoints of one palette.
	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
	} ends_t;

	function automatic ends_t calc_ends(input logic [7:0] y, input logic [7:0] d);
		logic signed [9:0] lo;
		logic signed [9:0] hi;
		ends_t e;
		lo = $signed({2'b00, y}) - $signed({3'b000, d[7:1]});
		hi = lo + $signed({2'b00, d});
		e.lo = lo < 0 ? 8'd0 : lo[7:0];
		e.hi = hi > 10'sd255 ? PIX_MAX : (hi < 0 ? 8'd0 : hi[7:0]);
		return e;
	endfunction

	// Weighted mix (wl*lo + (16-wl)*hi) >> 4.
	function automatic logic [7:0] mix(input ends_t e, input logic [4:0] wl);
		logic [12:0] s;
		s = {5'b00000, e.lo} * {8'h00, wl} + {5'b00000, e.hi} * {8'h00, 5'd16 - wl};
		return s[11:4];
	endfunction

endpackage

// ----- design/yuv420_block_decoder_4x4_core.sv -----
// Top level of the 4x4 YUV 4:2:0 block decoder.
// Decodes one 32-byte compressed block per clock, unless stalled, into a 4x4
// luma tile and 2x2 U and V samples. Three pipeline stages (mode decode and
// endpoints, palette mixing, pixel selection) lie between an accepted input
// word and a valid output word; throughput is one block per cycle when no
// stall holds the pipeline. A stall on the output freezes the whole pipeline,
// and the input stall is the output stall while the last stage holds a word.
module yuv420_block_decoder_4x4_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ybd_pkg::blk_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ybd_pkg::blk_out_t out_data
);
	import ybd_pkg::*;

	logic           v_s1, v_s2, v_s3;
	logic           en;
	logic [2:0]     mode_s1, mode_s2;
	logic [255:0]   bytes_s1, bytes_s2;
	ends_t          ends_s1 [4];
	logic [7:0]     pal8_s2 [8];
	logic [7:0]     qpal_s2 [4][4];

	// advance everything unless the output word is held
	assign en        = !(v_s3 && out_stall);
	assign in_stall  = !en;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	ybd_decode u_dec (
		.clk(clk), .arst_n(arst_n), .en(en), .blk(in_data),
		.mode_s1(mode_s1), .bytes_s1(bytes_s1), .ends_s1(ends_s1)
	);

	ybd_palette u_pal (
		.clk(clk), .arst_n(arst_n), .en(en), .mode_s1(mode_s1), .bytes_s1(bytes_s1),
		.ends_s1(ends_s1), .mode_s2(mode_s2), .bytes_s2(bytes_s2),
		.pal8_s2(pal8_s2), .qpal_s2(qpal_s2)
	);

	ybd_pixel u_pix (
		.clk(clk), .en(en), .mode_s2(mode_s2), .bytes_s2(bytes_s2),
		.pal8_s2(pal8_s2), .qpal_s2(qpal_s2), .res_s3(out_data)
	);

	a_in_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s3 && out_stall))
		else $error("input stalled with free output stage");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !(v_s3 && out_stall)) |=> v_s3)
		else $error("stage 2 word lost");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_stall) |=> (v_s3 && $stable(out_data) && $stable(v_s2)))
		else $error("pipeline moved under stall");
endmodule

// ----- design/ybd_decode.sv -----
// Stage 1: mode decode and palette endpoints.
module ybd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ybd_pkg::blk_in_t  blk,
	output logic [2:0]        mode_s1,
	output logic [255:0]      bytes_s1,
	output ybd_pkg::ends_t    ends_s1 [4]
);
	import ybd_pkg::*;

	logic [255:0] b;
	logic [2:0]   mode;
	logic [7:0]   d0;
	ends_t        e [4];

	assign b = blk;

	always_comb begin
		if (b[31:24] != 8'd0) mode = MODE_PAL4;
		else case (b[39:32])
			8'd0:      mode = MODE_FLAT;
			CODE_SUB:  mode = MODE_SUB;
			CODE_BIT1: mode = MODE_BIT1;
			CODE_PAL8: mode = MODE_PAL8;
			CODE_QUAD: mode = MODE_QUAD;
			CODE_RAW:  mode = MODE_RAW;
			default:   mode = MODE_CHECK;
		endcase
		d0 = (b[31:24] != 8'd0) ? b[31:24] : b[47:40];
		e[0] = calc_ends(b[7:0], d0);
		e[1] = calc_ends(b[71:64], b[95:88]);
		e[2] = calc_ends(b[135:128], b[159:152]);
		e[3] = calc_ends(b[167:160], b[191:184]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= MODE_FLAT;
		end else if (en) begin
			mode_s1 <= mode;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bytes_s1 <= b;
			for (int i = 0; i < 4; i++) ends_s1[i] <= e[i];
		end
	end
endmodule

// ----- design/ybd_palette.sv -----
// Stage 2: palette entries from endpoints.
module ybd_palette (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [2:0]      mode_s1,
	input  logic [255:0]    bytes_s1,
	input  ybd_pkg::ends_t  ends_s1 [4],
	output logic [2:0]      mode_s2,
	output logic [255:0]    bytes_s2,
	output logic [7:0]      pal8_s2 [8],
	output logic [7:0]      qpal_s2 [4][4]
);
	import ybd_pkg::*;

	localparam logic [4:0] W8 [6] = '{5'd14, 5'd11, 5'd9, 5'd7, 5'd5, 5'd2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s2 <= MODE_FLAT;
		end else if (en) begin
			mode_s2 <= mode_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bytes_s2 <= bytes_s1;
			pal8_s2[0] <= ends_s1[0].lo;
			pal8_s2[7] <= ends_s1[0].hi;
			for (int k = 0; k < 6; k++) pal8_s2[k + 1] <= mix(ends_s1[0], W8[k]);
			for (int q = 0; q < 4; q++) begin
				qpal_s2[q][0] <= ends_s1[q].lo;
				qpal_s2[q][1] <= mix(ends_s1[q], 5'd11);
				qpal_s2[q][2] <= mix(ends_s1[q], 5'd5);
				qpal_s2[q][3] <= ends_s1[q].hi;
			end
		end
	end
endmodule

// ----- design/ybd_pixel.sv -----
// Stage 3: per-pixel index selection and output packing.
module ybd_pixel (
	input  logic              clk,
	input  logic              en,
	input  logic [2:0]        mode_s2,
	input  logic [255:0]      bytes_s2,
	input  logic [7:0]        pal8_s2 [8],
	input  logic [7:0]        qpal_s2 [4][4],
	output ybd_pkg::blk_out_t res_s3
);
	import ybd_pkg::*;

	logic [7:0]  by [32];
	logic [7:0]  pix [4][4];
	logic [31:0] u, v;
	logic [15:0] bits;
	logic [23:0] w [2];
	logic [1:0]  i2;
	logic [2:0]  i3;
	blk_out_t    r;

	always_comb begin
		for (int n = 0; n < 32; n++) by[n] = bytes_s2[8*n +: 8];
		bits = {by[6], by[7]};
		w[0] = {by[10], by[11], by[12]};
		w[1] = {by[13], by[14], by[15]};
		u = {4{by[1]}};
		v = {4{by[2]}};
		for (int rr = 0; rr < 4; rr++) begin
			for (int c = 0; c < 4; c++) begin
				i2 = '0;
				i3 = '0;
				case (mode_s2)
					MODE_PAL4: begin
						i2 = by[4 + rr][6 - 2*c +: 2];
						pix[rr][c] = qpal_s2[0][i2];
					end
					MODE_FLAT: pix[rr][c] = by[0];
					MODE_SUB: begin
						i2 = by[6][6 - 2*((rr/2)*2 + c/2) +: 2];
						pix[rr][c] = qpal_s2[0][i2];
					end
					MODE_BIT1: pix[rr][c] = qpal_s2[0][{1'b0, bits[15 - 4*rr - c]}];
					MODE_PAL8: begin
						i3 = w[rr/2][21 - 12*(rr%2) - 3*c +: 3];
						pix[rr][c] = pal8_s2[i3];
					end
					MODE_QUAD: begin
						i2 = by[12 + rr][6 - 2*c +: 2];
						pix[rr][c] = qpal_s2[(rr/2)*2 + c/2][i2];
					end
					MODE_RAW: pix[rr][c] = by[16 + 4*rr + c];
					default: pix[rr][c] = (((c == 0) || (c == 3)) == ((rr % 2) == 0))
						? PIX_MAX : 8'd0;
				endcase
			end
		end
		case (mode_s2)
			MODE_QUAD: begin
				u = {by[21], by[17], by[9], by[1]};
				v = {by[22], by[18], by[10], by[2]};
			end
			MODE_RAW: begin
				u = {by[11], by[10], by[9], by[8]};
				v = {by[15], by[14], by[13], by[12]};
			end
			MODE_CHECK: begin
				u = {PIX_MAX, 8'd0, 8'd0, PIX_MAX};
				v = {8'd0, PIX_MAX, PIX_MAX, 8'd0};
			end
			default: ;
		endcase
		r.luma_row0 = {pix[0][3], pix[0][2], pix[0][1], pix[0][0]};
		r.luma_row1 = {pix[1][3], pix[1][2], pix[1][1], pix[1][0]};
		r.luma_row2 = {pix[2][3], pix[2][2], pix[2][1], pix[2][0]};
		r.luma_row3 = {pix[3][3], pix[3][2], pix[3][1], pix[3][0]};
		r.chroma_u  = u;
		r.chroma_v  = v;
	end

	always_ff @(posedge clk) begin
		if (en) res_s3 <= r;
	end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 4x4 YUV 4:2:0 block decoder.
module tb_top;
	import ybd_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	blk_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	blk_out_t out_data;

	blk_out_t tiles_due[$];
	int       n_err;
	int       n_blocks;
	int       n_tiles;
	bit       idle_en;
	int       hold_len;
	int       hold_req;
	int       hold_seen;

	yuv420_block_decoder_4x4_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [7:0] clip8(input int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	// Palette entry k of n levels, mixed from lo and hi in sixteenths.
	function automatic logic [7:0] pal_entry(input logic [7:0] y, input logic [7:0] d,
			input int k, input bit eight);
		int lo, hi, wl;
		lo = int'(y) - int'(d >> 1);
		hi = lo + int'(d);
		lo = clip8(lo);
		hi = clip8(hi);
		if (eight) begin
			case (k)
				0: wl = 16;
				1: wl = 14;
				2: wl = 11;
				3: wl = 9;
				4: wl = 7;
				5: wl = 5;
				6: wl = 2;
				default: wl = 0;
			endcase
		end else begin
			case (k)
				0: wl = 16;
				1: wl = 11;
				2: wl = 5;
				default: wl = 0;
			endcase
		end
		return 8'((lo * wl + hi * (16 - wl)) >> 4);
	endfunction

	function automatic blk_out_t decode_tile(input blk_in_t w);
		logic [7:0] b [32];
		logic [7:0] px [4][4];
		logic [7:0] cu [4];
		logic [7:0] cv [4];
		logic [23:0] w3;
		logic [15:0] bits;
		int q, idx;
		blk_out_t t;
		for (int n = 0; n < 32; n++)
			b[n] = w[64 * (n / 8) + 8 * (n % 8) +: 8];
		for (int i = 0; i < 4; i++) begin
			cu[i] = b[1];
			cv[i] = b[2];
		end
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (b[3] != 0) begin
					px[r][c] = pal_entry(b[0], b[3], (b[4 + r] >> (6 - 2 * c)) & 3, 0);
				end else if (b[4] == 0) begin
					px[r][c] = b[0];
				end else if (b[4] == CODE_SUB) begin
					q = (r / 2) * 2 + c / 2;
					px[r][c] = pal_entry(b[0], b[5], (b[6] >> (6 - 2 * q)) & 3, 0);
				end else if (b[4] == CODE_BIT1) begin
					bits = {b[6], b[7]};
					px[r][c] = pal_entry(b[0], b[5], bits[15 - 4 * r - c], 0);
				end else if (b[4] == CODE_PAL8) begin
					w3 = (r < 2) ? {b[10], b[11], b[12]} : {b[13], b[14], b[15]};
					idx = (w3 >> (21 - 12 * (r % 2) - 3 * c)) & 7;
					px[r][c] = pal_entry(b[0], b[5], idx, 1);
				end else if (b[4] == CODE_QUAD) begin
					q = (r / 2) * 2 + c / 2;
					idx = (b[12 + r] >> (6 - 2 * c)) & 3;
					case (q)
						0: px[r][c] = pal_entry(b[0], b[5], idx, 0);
						1: px[r][c] = pal_entry(b[8], b[11], idx, 0);
						2: px[r][c] = pal_entry(b[16], b[19], idx, 0);
						default: px[r][c] = pal_entry(b[20], b[23], idx, 0);
					endcase
				end else if (b[4] == CODE_RAW) begin
					px[r][c] = b[16 + 4 * r + c];
				end else begin
					px[r][c] = (((c == 0) || (c == 3)) == (r % 2 == 0)) ? 8'd255 : 8'd0;
				end
			end
		if (b[3] == 0 && b[4] == CODE_QUAD) begin
			cu = '{b[1], b[9], b[17], b[21]};
			cv = '{b[2], b[10], b[18], b[22]};
		end else if (b[3] == 0 && b[4] == CODE_RAW) begin
			cu = '{b[8], b[9], b[10], b[11]};
			cv = '{b[12], b[13], b[14], b[15]};
		end else if (b[3] == 0 && !(b[4] inside {8'd0, CODE_SUB, CODE_BIT1, CODE_PAL8})) begin
			cu = '{8'd255, 8'd0, 8'd0, 8'd255};
			cv = '{8'd0, 8'd255, 8'd255, 8'd0};
		end
		t.luma_row0 = {px[0][3], px[0][2], px[0][1], px[0][0]};
		t.luma_row1 = {px[1][3], px[1][2], px[1][1], px[1][0]};
		t.luma_row2 = {px[2][3], px[2][2], px[2][1], px[2][0]};
		t.luma_row3 = {px[3][3], px[3][2], px[3][1], px[3][0]};
		t.chroma_u = {cu[3], cu[2], cu[1], cu[0]};
		t.chroma_v = {cv[3], cv[2], cv[1], cv[0]};
		return t;
	endfunction

	// Send one block; hold the word until accepted, keep valid up for the next one.
	task automatic send_block(input blk_in_t w);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		tiles_due.push_back(decode_tile(w));
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_blocks++;
	endtask

	function automatic blk_in_t rand_block();
		blk_in_t w;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return w;
	endfunction

	// Mostly known modes with random content, some noise.
	function automatic blk_in_t rand_mode_block();
		blk_in_t w;
		w = rand_block();
		case ($urandom_range(0, 9))
			0: w[31:24] = 8'd0;
			1: w[39:24] = 16'd0;
			2: w[39:24] = {CODE_SUB, 8'd0};
			3: w[39:24] = {CODE_BIT1, 8'd0};
			4, 5: w[39:24] = {CODE_PAL8, 8'd0};
			6: w[39:24] = {CODE_QUAD, 8'd0};
			7: w[39:24] = {CODE_RAW, 8'd0};
			default: ;
		endcase
		return w;
	endfunction

	// Receiver stall: random bursts, or one long hold on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_len <= 0;
			hold_seen <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			out_stall <= 1'b1;
			hold_len <= 40;
		end else if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else if (idle_en && !out_stall && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			hold_len <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		blk_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tiles_due.size() == 0) begin
				$display("%0t: unexpected tile %h", $time, out_data);
				n_err++;
			end else begin
				e = tiles_due.pop_front();
				n_tiles++;
				if (e.luma_row0 !== out_data.luma_row0)
					$display("%0t: luma_row0 exp %h got %h", $time, e.luma_row0, out_data.luma_row0);
				if (e.luma_row1 !== out_data.luma_row1)
					$display("%0t: luma_row1 exp %h got %h", $time, e.luma_row1, out_data.luma_row1);
				if (e.luma_row2 !== out_data.luma_row2)
					$display("%0t: luma_row2 exp %h got %h", $time, e.luma_row2, out_data.luma_row2);
				if (e.luma_row3 !== out_data.luma_row3)
					$display("%0t: luma_row3 exp %h got %h", $time, e.luma_row3, out_data.luma_row3);
				if (e.chroma_u !== out_data.chroma_u)
					$display("%0t: chroma_u exp %h got %h", $time, e.chroma_u, out_data.chroma_u);
				if (e.chroma_v !== out_data.chroma_v)
					$display("%0t: chroma_v exp %h got %h", $time, e.chroma_v, out_data.chroma_v);
				if (e !== out_data) n_err++;
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (tiles_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		blk_in_t w;
		logic [7:0] codes [8] = '{8'd0, CODE_SUB, CODE_BIT1, CODE_PAL8, CODE_QUAD,
			CODE_RAW, 8'd3, 8'd255};
		send_block('0);
		send_block('1);
		for (int i = 0; i < 8; i++) begin
			w = rand_block();
			w[39:24] = {codes[i], 8'd0};
			send_block(w);
		end
		// Clamp at both ends: small Y with large D, large Y with large D.
		w = rand_block();
		w[31:0] = {8'hFF, 8'h00, 8'h00, 8'h00};
		w[39:32] = 8'h1B;
		send_block(w);
		w[31:0] = {8'hFF, 8'hFF, 8'h00, 8'hFF};
		send_block(w);
		w = '1;
		w[39:24] = {CODE_PAL8, 8'd0};
		w[7:0] = 8'h00;
		send_block(w);
		w = '1;
		w[39:24] = {CODE_QUAD, 8'd0};
		send_block(w);
		w = '0;
		w[39:24] = {CODE_BIT1, 8'd0};
		w[47:40] = 8'hFF;
		w[63:48] = 16'hA5C3;
		w[7:0] = 8'h80;
		send_block(w);
		drain();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) send_block(rand_mode_block());
	endtask

	task automatic test_backpressure();
		// Long receiver hold while the sender keeps offering.
		in_valid <= 1'b0;
		@(posedge clk);
		hold_req++;
		for (int i = 0; i < 20; i++) send_block(rand_mode_block());
		drain();
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		n_err = 0;
		n_blocks = 0;
		n_tiles = 0;
		idle_en = 1'b1;
		hold_req = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(800);
		test_backpressure();
		drain();
		test_random(700);
		idle_en = 1'b0;
		test_random(200);
		drain();
		repeat (10) @(posedge clk);
		if (tiles_due.size() != 0) n_err++;
		$display("Decoded %0d blocks into %0d tiles across all modes,", n_blocks, n_tiles);
		$display("with random gaps, a long output hold and a gap-free tail.");
		if (n_err == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
